// ----- design/one_wire_bus_master_core_macros.svh -----
// Assertion helpers for the 1-Wire master core.
// Both expect clk and rst_n in the scope where they are used.
`ifndef ONE_WIRE_BUS_MASTER_CORE_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_CORE_MACROS_SVH

// Consequent checked on the same edge as the antecedent
`define OWBM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked on the edge after the antecedent
`define OWBM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/owbm_pkg.sv -----
`default_nettype none

package owbm_pkg;

    localparam int TIME_W      = 9;
    localparam int QUEUE_DEPTH = 2;

    // Request codes carried in req_type
    typedef enum logic [2:0] {
        REQ_TICK    = 3'd0,
        REQ_RESET   = 3'd1,
        REQ_WR_BYTE = 3'd2,
        REQ_RD_BYTE = 3'd3,
        REQ_WR_BIT  = 3'd4,
        REQ_RD_BIT  = 3'd5
    } req_code_t;

    // Register indexes
    typedef enum logic [2:0] {
        CFG_RESET_LOW     = 3'd0,
        CFG_PRESENCE_WAIT = 3'd1,
        CFG_RESET_TAIL    = 3'd2,
        CFG_SHORT_LOW     = 3'd3,
        CFG_ZERO_LOW      = 3'd4,
        CFG_WRITE_SLOT    = 3'd5,
        CFG_READ_SAMPLE   = 3'd6,
        CFG_READ_TAIL     = 3'd7
    } cfg_idx_t;

    // Register reset values, in microseconds
    localparam logic [TIME_W-1:0] RST_RESET_LOW     = 9'd480;
    localparam logic [TIME_W-1:0] RST_PRESENCE_WAIT = 9'd70;
    localparam logic [TIME_W-1:0] RST_RESET_TAIL    = 9'd410;
    localparam logic [TIME_W-1:0] RST_SHORT_LOW     = 9'd6;
    localparam logic [TIME_W-1:0] RST_ZERO_LOW      = 9'd60;
    localparam logic [TIME_W-1:0] RST_WRITE_SLOT    = 9'd70;
    localparam logic [TIME_W-1:0] RST_READ_SAMPLE   = 9'd12;
    localparam logic [TIME_W-1:0] RST_READ_TAIL     = 9'd55;

    typedef struct packed {
        logic [TIME_W-1:0] reset_low_time;
        logic [TIME_W-1:0] presence_wait_time;
        logic [TIME_W-1:0] reset_tail_time;
        logic [TIME_W-1:0] short_low_time;
        logic [TIME_W-1:0] zero_low_time;
        logic [TIME_W-1:0] write_slot_time;
        logic [TIME_W-1:0] read_sample_time;
        logic [TIME_W-1:0] read_tail_time;
    } cfg_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] tx_data;
        logic       bus_sample;
    } req_t;

    typedef struct packed {
        logic       pin_drive_enable;
        logic       pin_level;
        logic       busy_res;
        logic       done_res;
        logic       presence;
        logic [7:0] rx_data;
        logic       rejected;
    } res_t;

    // Item class decided by the front end
    typedef enum logic [1:0] {
        CLS_TICK = 2'd0,
        CLS_CMD  = 2'd1,
        CLS_NOP  = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t       cls;
        req_code_t  op;
        logic [7:0] tx_data;
        logic       bus_sample;
    } item_t;

    // A zero length lasts one tick
    function automatic logic [TIME_W-1:0] dur(input logic [TIME_W-1:0] v);
        return (v == '0) ? TIME_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ----- design/owbm_regs.sv -----
`default_nettype none

module owbm_regs (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output owbm_pkg::cfg_t     cfg
);

    owbm_pkg::cfg_t    cfg_reg;
    owbm_pkg::cfg_idx_t idx;
    logic              wr_en;
    logic [owbm_pkg::TIME_W-1:0] rd_val;

    assign pready = 1'b1;
    assign idx    = owbm_pkg::cfg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    // Register writes on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time     <= owbm_pkg::RST_RESET_LOW;
            cfg_reg.presence_wait_time <= owbm_pkg::RST_PRESENCE_WAIT;
            cfg_reg.reset_tail_time    <= owbm_pkg::RST_RESET_TAIL;
            cfg_reg.short_low_time     <= owbm_pkg::RST_SHORT_LOW;
            cfg_reg.zero_low_time      <= owbm_pkg::RST_ZERO_LOW;
            cfg_reg.write_slot_time    <= owbm_pkg::RST_WRITE_SLOT;
            cfg_reg.read_sample_time   <= owbm_pkg::RST_READ_SAMPLE;
            cfg_reg.read_tail_time     <= owbm_pkg::RST_READ_TAIL;
        end
        else if (wr_en)
        begin
            unique case (idx)
                owbm_pkg::CFG_RESET_LOW:     cfg_reg.reset_low_time     <= pwdata[8:0];
                owbm_pkg::CFG_PRESENCE_WAIT: cfg_reg.presence_wait_time <= pwdata[8:0];
                owbm_pkg::CFG_RESET_TAIL:    cfg_reg.reset_tail_time    <= pwdata[8:0];
                owbm_pkg::CFG_SHORT_LOW:     cfg_reg.short_low_time     <= pwdata[8:0];
                owbm_pkg::CFG_ZERO_LOW:      cfg_reg.zero_low_time      <= pwdata[8:0];
                owbm_pkg::CFG_WRITE_SLOT:    cfg_reg.write_slot_time    <= pwdata[8:0];
                owbm_pkg::CFG_READ_SAMPLE:   cfg_reg.read_sample_time   <= pwdata[8:0];
                default:                     cfg_reg.read_tail_time     <= pwdata[8:0];
            endcase
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (idx)
            owbm_pkg::CFG_RESET_LOW:     rd_val = cfg_reg.reset_low_time;
            owbm_pkg::CFG_PRESENCE_WAIT: rd_val = cfg_reg.presence_wait_time;
            owbm_pkg::CFG_RESET_TAIL:    rd_val = cfg_reg.reset_tail_time;
            owbm_pkg::CFG_SHORT_LOW:     rd_val = cfg_reg.short_low_time;
            owbm_pkg::CFG_ZERO_LOW:      rd_val = cfg_reg.zero_low_time;
            owbm_pkg::CFG_WRITE_SLOT:    rd_val = cfg_reg.write_slot_time;
            owbm_pkg::CFG_READ_SAMPLE:   rd_val = cfg_reg.read_sample_time;
            default:                     rd_val = cfg_reg.read_tail_time;
        endcase
        prdata = {23'd0, rd_val};
    end

endmodule

`default_nettype wire

// ----- design/owbm_front.sv -----
`default_nettype none

module owbm_front #(
    parameter int QUEUE_DEPTH = owbm_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire owbm_pkg::req_t req,
    output logic                item_valid,
    input  wire logic           item_ready,
    output owbm_pkg::item_t     item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    owbm_pkg::item_t  queue_mem [QUEUE_DEPTH];
    owbm_pkg::item_t  cls_item;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    // Classify the incoming beat
    always_comb
    begin
        cls_item.op         = owbm_pkg::req_code_t'(req.req_type);
        cls_item.tx_data    = req.tx_data;
        cls_item.bus_sample = req.bus_sample;
        unique case (req.req_type) inside
            owbm_pkg::REQ_TICK:
                cls_item.cls = owbm_pkg::CLS_TICK;
            owbm_pkg::REQ_RESET, owbm_pkg::REQ_WR_BYTE, owbm_pkg::REQ_RD_BYTE,
            owbm_pkg::REQ_WR_BIT, owbm_pkg::REQ_RD_BIT:
                cls_item.cls = owbm_pkg::CLS_CMD;
            default:
                cls_item.cls = owbm_pkg::CLS_NOP;
        endcase
    end

    assign req_ready  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = queue_mem[rd_ptr_reg];
    assign push       = req_valid && req_ready;
    assign pop        = item_valid && item_ready;

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/owbm_engine.sv -----
`default_nettype none

module owbm_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire owbm_pkg::cfg_t  cfg,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire owbm_pkg::item_t item,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output owbm_pkg::res_t       res
);

`include "one_wire_bus_master_core_macros.svh"

    localparam int TW = owbm_pkg::TIME_W;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_WR_LOW   = 4'd4,
        PH_WR_HIGH  = 4'd5,
        PH_RD_LOW   = 4'd6,
        PH_RD_WAIT  = 4'd7,
        PH_RD_TAIL  = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        DRV_RELEASED = 2'b00,
        DRV_LOW      = 2'b10,
        DRV_HIGH     = 2'b11
    } drv_t;

    phase_t              phase_reg, phase_next;
    owbm_pkg::req_code_t op_reg, op_next;
    logic [TW-1:0]       timer_reg, timer_next;
    logic [3:0]          bits_reg, bits_next;
    logic [7:0]          shift_reg, shift_next;
    drv_t                drv_reg, drv_next;
    logic                pres_reg, pres_next;
    logic [7:0]          rx_reg, rx_next;
    logic                res_valid_reg, res_valid_next;
    owbm_pkg::res_t      res_reg, res_next;

    logic [TW-1:0]       timer_dec, low_len, slot_len;
    logic [3:0]          bits_dec;
    logic                done, rej, take;

    assign take       = !res_valid_reg || res_ready;
    assign item_ready = take;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    assign timer_dec = timer_reg - 1'b1;
    assign bits_dec  = bits_reg - 1'b1;
    assign low_len   = owbm_pkg::dur(shift_reg[0] ? cfg.short_low_time : cfg.zero_low_time);
    assign slot_len  = cfg.write_slot_time;

    // Phase sequencing for one beat
    always_comb
    begin
        phase_next = phase_reg;
        op_next    = op_reg;
        timer_next = timer_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        drv_next   = drv_reg;
        pres_next  = pres_reg;
        rx_next    = rx_reg;
        done       = 1'b0;
        rej        = 1'b0;

        if (item.cls == owbm_pkg::CLS_TICK && phase_reg != PH_IDLE)
        begin
            timer_next = timer_dec;
            if (timer_dec == '0)
            begin
                unique case (phase_reg)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                        drv_next   = DRV_HIGH;
                        timer_next = owbm_pkg::dur(cfg.presence_wait_time);
                    end
                    PH_RST_WAIT:
                    begin
                        pres_next  = !item.bus_sample;
                        phase_next = PH_RST_TAIL;
                        drv_next   = DRV_RELEASED;
                        timer_next = owbm_pkg::dur(cfg.reset_tail_time);
                    end
                    PH_RST_TAIL:
                    begin
                        done = 1'b1;
                    end
                    PH_WR_LOW:
                    begin
                        phase_next = PH_WR_HIGH;
                        drv_next   = DRV_HIGH;
                        timer_next = (slot_len > low_len) ? slot_len - low_len : TW'(1);
                    end
                    PH_WR_HIGH:
                    begin
                        shift_next = {1'b0, shift_reg[7:1]};
                        bits_next  = bits_dec;
                        if (bits_dec != '0)
                        begin
                            // next slot of the byte
                            phase_next = PH_WR_LOW;
                            drv_next   = DRV_LOW;
                            timer_next = owbm_pkg::dur(shift_reg[1] ? cfg.short_low_time
                                                                    : cfg.zero_low_time);
                        end
                        else
                        begin
                            done = 1'b1;
                        end
                    end
                    PH_RD_LOW:
                    begin
                        phase_next = PH_RD_WAIT;
                        drv_next   = DRV_RELEASED;
                        timer_next = owbm_pkg::dur(cfg.read_sample_time);
                    end
                    PH_RD_WAIT:
                    begin
                        shift_next = {item.bus_sample, shift_reg[7:1]};
                        phase_next = PH_RD_TAIL;
                        timer_next = owbm_pkg::dur(cfg.read_tail_time);
                    end
                    PH_RD_TAIL:
                    begin
                        bits_next = bits_dec;
                        if (bits_dec != '0)
                        begin
                            phase_next = PH_RD_LOW;
                            drv_next   = DRV_LOW;
                            timer_next = owbm_pkg::dur(cfg.short_low_time);
                        end
                        else
                        begin
                            rx_next = (op_reg == owbm_pkg::REQ_RD_BIT) ? {7'd0, shift_reg[7]}
                                                                       : shift_reg;
                            done    = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
                if (done)
                begin
                    phase_next = PH_IDLE;
                    timer_next = '0;
                end
            end
        end
        else if (item.cls == owbm_pkg::CLS_CMD)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rej = 1'b1;
            end
            else
            begin
                op_next  = item.op;
                drv_next = DRV_LOW;
                unique case (item.op)
                    owbm_pkg::REQ_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                        timer_next = owbm_pkg::dur(cfg.reset_low_time);
                    end
                    owbm_pkg::REQ_WR_BYTE:
                    begin
                        shift_next = item.tx_data;
                        bits_next  = 4'd8;
                        phase_next = PH_WR_LOW;
                        timer_next = owbm_pkg::dur(item.tx_data[0] ? cfg.short_low_time
                                                                   : cfg.zero_low_time);
                    end
                    owbm_pkg::REQ_WR_BIT:
                    begin
                        shift_next = {7'd0, item.tx_data[0]};
                        bits_next  = 4'd1;
                        phase_next = PH_WR_LOW;
                        timer_next = owbm_pkg::dur(item.tx_data[0] ? cfg.short_low_time
                                                                   : cfg.zero_low_time);
                    end
                    owbm_pkg::REQ_RD_BYTE:
                    begin
                        shift_next = '0;
                        bits_next  = 4'd8;
                        phase_next = PH_RD_LOW;
                        timer_next = owbm_pkg::dur(cfg.short_low_time);
                    end
                    default:
                    begin
                        shift_next = '0;
                        bits_next  = 4'd1;
                        phase_next = PH_RD_LOW;
                        timer_next = owbm_pkg::dur(cfg.short_low_time);
                    end
                endcase
            end
        end
    end

    // Result word built from the updated state
    always_comb
    begin
        res_next.pin_drive_enable = drv_next[1];
        res_next.pin_level        = drv_next[1] ? drv_next[0] : 1'b1;
        res_next.busy_res         = (phase_next != PH_IDLE);
        res_next.done_res         = done;
        res_next.presence         = pres_next;
        res_next.rx_data          = rx_next;
        res_next.rejected         = rej;

        res_valid_next = res_valid_reg;
        if (item_valid && take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    // State and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            op_reg        <= owbm_pkg::REQ_TICK;
            timer_reg     <= '0;
            bits_reg      <= '0;
            shift_reg     <= '0;
            drv_reg       <= DRV_RELEASED;
            pres_reg      <= 1'b0;
            rx_reg        <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (item_valid && take)
            begin
                phase_reg <= phase_next;
                op_reg    <= op_next;
                timer_reg <= timer_next;
                bits_reg  <= bits_next;
                shift_reg <= shift_next;
                drv_reg   <= drv_next;
                pres_reg  <= pres_next;
                rx_reg    <= rx_next;
                res_reg   <= res_next;
            end
        end
    end

    `OWBM_ASSERT_SAME(a_done_idle, res_valid_reg && res_reg.done_res, !res_reg.busy_res && !res_reg.rejected, "done result still busy or rejected")
    `OWBM_ASSERT_SAME(a_reject_busy, res_valid_reg && res_reg.rejected, res_reg.busy_res, "rejection reported while idle")
    `OWBM_ASSERT_SAME(a_idle_timer, phase_reg == PH_IDLE, timer_reg == '0, "phase timer left running while idle")
    `OWBM_ASSERT_NEXT(a_take_loads, item_valid && item_ready, res_valid_reg, "taken item left no result")

endmodule

`default_nettype wire

// ----- design/one_wire_bus_master_core.sv -----
// Channel  | Dir | Handshake         | Beat
// ---------+-----+-------------------+------------------------------------------
// req      | in  | req_valid/ready   | owbm_pkg::req_t: tick, command or no-op
// res      | out | res_valid/ready   | owbm_pkg::res_t: pin state, status, data
// apb      | in  | psel/penable      | 9-bit phase lengths at paddr 4*index
//
// One result per request beat, sustained at one beat per clock while res_ready stays high.
// A taken beat is written into the front queue, then popped by the engine once its
// output register is free; its result is registered and offered on res.
// The front queue holds QUEUE_DEPTH beats; the engine advances one beat
// per cycle whenever its output register is empty or being drained.
// rst_n clears queue, phase state and result register asynchronously.
// A stalled result only stops the engine; the queue keeps taking beats until full.
`default_nettype none

module one_wire_bus_master_core #(
    parameter int QUEUE_DEPTH = owbm_pkg::QUEUE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire owbm_pkg::req_t req,
    output logic                res_valid,
    input  wire logic           res_ready,
    output owbm_pkg::res_t      res,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [4:0]     paddr,
    input  wire logic [31:0]    pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    owbm_pkg::cfg_t  cfg;
    owbm_pkg::item_t item;
    logic            item_valid;
    logic            item_ready;

    // Configuration registers
    owbm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Accept and classify, queue ahead of the engine
    owbm_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item)
    );

    // Slot timing and bus control
    owbm_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

endmodule

`default_nettype wire
